// ----- rtl/set_assoc_lru_cache_tag_sim_defines.svh -----
// Assertion macros used by the cache tag simulator RTL.
`ifndef SET_ASSOC_LRU_CACHE_TAG_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAG_SIM_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define SALRU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("salru: same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define SALRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("salru: next-cycle check failed");

`endif

// ----- rtl/salru_pkg.sv -----
// Shared constants and types of the cache tag simulator.
package salru_pkg;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    localparam int SET_BITS_W   = 3;
    localparam int WAYS_W       = 4;
    localparam int BLOCK_BITS_W = 5;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;

    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_MAX = 5'd16;

    localparam int CNT_W = 32;

    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
        logic last;
    } res_flags_t;

endpackage

// ----- rtl/salru_ram.sv -----
// Generic single-port-write, registered-read RAM.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/salru_front.sv -----
// Front end: takes an access, splits the address into set and tag, picks the ways in use.
module salru_front #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 48
) (
    input  logic                                  in_valid,
    input  logic [salru_pkg::OP_W-1:0]            op,
    input  logic [ADDR_BITS-1:0]                  address,
    input  logic [salru_pkg::SET_BITS_W-1:0]      set_bits,
    input  logic [salru_pkg::WAYS_W-1:0]          ways_in_use,
    input  logic [salru_pkg::BLOCK_BITS_W-1:0]    block_bits,
    output logic                                  acc_valid,
    output logic [MAX_SET_BITS-1:0]               acc_set,
    output logic [ADDR_BITS-3:0]                  acc_tag,
    output logic [MAX_WAYS-1:0]                   acc_mask,
    output logic                                  acc_twice
);
    import salru_pkg::*;

    localparam int TAG_W = ADDR_BITS - 2;

    logic [4:0]           sb_c;
    logic [4:0]           nw_c;
    logic [4:0]           bb_c;
    logic [5:0]           shamt;
    logic [ADDR_BITS-1:0] blk_shift;
    logic [ADDR_BITS-1:0] tag_shift;
    logic [MAX_SET_BITS-1:0] set_mask;

    always_comb
    begin
        sb_c = {2'b00, set_bits};
        if (sb_c == 5'd0)
        begin
            sb_c = 5'd1;
        end
        else if (sb_c > 5'(MAX_SET_BITS))
        begin
            sb_c = 5'(MAX_SET_BITS);
        end

        nw_c = {1'b0, ways_in_use};
        if (nw_c == 5'd0)
        begin
            nw_c = 5'd1;
        end
        else if (nw_c > 5'(MAX_WAYS))
        begin
            nw_c = 5'(MAX_WAYS);
        end

        bb_c = block_bits;
        if (bb_c == 5'd0)
        begin
            bb_c = 5'd1;
        end
        else if (bb_c > BLOCK_BITS_MAX)
        begin
            bb_c = BLOCK_BITS_MAX;
        end

        for (int i = 0; i < MAX_SET_BITS; i++)
        begin
            set_mask[i] = (5'(i) < sb_c);
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            acc_mask[w] = (5'(w) < nw_c);
        end

        shamt     = 6'(bb_c) + 6'(sb_c);
        blk_shift = address >> bb_c;
        tag_shift = address >> shamt;
    end

    assign acc_set   = blk_shift[MAX_SET_BITS-1:0] & set_mask;
    assign acc_tag   = tag_shift[TAG_W-1:0];
    assign acc_twice = (op == OP_MODIFY);
    // drop the unused op code here, before it reaches the queue
    assign acc_valid = in_valid && (op != OP_NONE);

endmodule

// ----- rtl/salru_queue.sv -----
// Two-entry queue between the front end and the set update engine.
module salru_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_stall,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_stall,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_stall = (count_reg == 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/salru_back.sv -----
// Back end: set read, hit/fill/evict decision, LRU rank update, totals and result register.
`include "set_assoc_lru_cache_tag_sim_defines.svh"

module salru_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_stall,
    input  logic [MAX_SET_BITS-1:0]       q_set,
    input  logic [ADDR_BITS-3:0]          q_tag,
    input  logic [MAX_WAYS-1:0]           q_mask,
    input  logic                          q_twice,
    output logic                          out_valid,
    input  logic                          out_stall,
    output salru_pkg::res_flags_t         res_flags,
    output logic [salru_pkg::CNT_W-1:0]   hit_total,
    output logic [salru_pkg::CNT_W-1:0]   miss_total,
    output logic [salru_pkg::CNT_W-1:0]   evict_total
);
    import salru_pkg::*;

    localparam int TAG_W    = ADDR_BITS - 2;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NUM_SETS = 2 ** MAX_SET_BITS;
    localparam int RANK_OFF = MAX_WAYS;
    localparam int TAG_OFF  = MAX_WAYS * (1 + RANK_W);
    localparam int ROW_W    = MAX_WAYS * (1 + RANK_W + TAG_W);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [MAX_WAYS-1:0]     mask_reg;
    logic                    twice_reg;
    logic                    twice_next;
    logic [MAX_SET_BITS-1:0] last_set_reg;
    logic                    last_ok_reg;
    logic [NUM_SETS-1:0]     row_init_reg;
    logic [MAX_WAYS-1:0]     row_valid_reg;
    logic [RANK_W-1:0]       row_rank_reg [MAX_WAYS];
    logic [TAG_W-1:0]        row_tag_reg  [MAX_WAYS];
    logic                    out_valid_reg;
    logic                    out_valid_next;
    res_flags_t              flags_reg;
    logic [CNT_W-1:0]        hits_reg;
    logic [CNT_W-1:0]        misses_reg;
    logic [CNT_W-1:0]        evicts_reg;

    logic                    pop;
    logic                    fire;
    logic                    done;
    logic                    bypass;
    logic [ROW_W-1:0]        rd_row;
    logic [ROW_W-1:0]        wr_row;

    logic [MAX_WAYS-1:0]     hit_vec;
    logic [MAX_WAYS-1:0]     free_vec;
    logic                    hit_any;
    logic                    free_any;
    logic [WAY_W-1:0]        hit_way;
    logic [WAY_W-1:0]        free_way;
    logic [WAY_W-1:0]        vic_way;
    logic [WAY_W-1:0]        pick;
    logic                    do_evict;
    logic [MAX_WAYS-1:0]     new_valid;
    logic [RANK_W-1:0]       new_rank [MAX_WAYS];
    logic [TAG_W-1:0]        new_tag  [MAX_WAYS];

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (fire),
        .wr_addr (set_reg),
        .wr_data (wr_row),
        .rd_en   (pop),
        .rd_addr (q_set),
        .rd_data (rd_row)
    );

    assign fire    = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign done    = fire && !twice_reg;
    assign q_stall = !((state_reg == ST_IDLE) || done);
    assign pop     = q_valid && !q_stall;
    assign bypass  = last_ok_reg && (last_set_reg == set_reg);

    always_comb
    begin
        hit_vec  = '0;
        free_vec = '0;
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_way  = '0;
        free_way = '0;
        vic_way  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            hit_vec[w]  = mask_reg[w] && row_valid_reg[w] && (row_tag_reg[w] == tag_reg);
            free_vec[w] = mask_reg[w] && !row_valid_reg[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (free_vec[w])
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (mask_reg[w] && (row_rank_reg[w] > row_rank_reg[vic_way]))
            begin
                vic_way = WAY_W'(w);
            end
        end
        do_evict = !hit_any && !free_any;
        pick     = hit_any ? hit_way : (free_any ? free_way : vic_way);

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            new_valid[w] = row_valid_reg[w];
            new_rank[w]  = row_rank_reg[w];
            new_tag[w]   = row_tag_reg[w];
            if (WAY_W'(w) == pick)
            begin
                new_valid[w] = 1'b1;
                new_rank[w]  = '0;
                new_tag[w]   = tag_reg;
            end
            else if (mask_reg[w] && row_valid_reg[w]
                     && (!hit_any || (row_rank_reg[w] < row_rank_reg[pick])))
            begin
                new_rank[w] = (row_rank_reg[w] >= RANK_MAX) ? RANK_MAX
                                                            : row_rank_reg[w] + 1'b1;
            end
        end

        wr_row[MAX_WAYS-1:0] = new_valid;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            wr_row[RANK_OFF + w*RANK_W +: RANK_W] = new_rank[w];
            wr_row[TAG_OFF + w*TAG_W +: TAG_W]    = new_tag[w];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next = pop ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        twice_next = twice_reg;
        if (pop)
        begin
            twice_next = q_twice;
        end
        else if (fire)
        begin
            twice_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            twice_reg     <= 1'b0;
            last_ok_reg   <= 1'b0;
            row_init_reg  <= '0;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            twice_reg     <= twice_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                last_ok_reg           <= 1'b1;
                row_init_reg[set_reg] <= 1'b1;
                if (hit_any)
                begin
                    hits_reg <= (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
                end
                else
                begin
                    misses_reg <= (misses_reg == '1) ? misses_reg : misses_reg + 1'b1;
                end
                if (do_evict)
                begin
                    evicts_reg <= (evicts_reg == '1) ? evicts_reg : evicts_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            set_reg  <= q_set;
            tag_reg  <= q_tag;
            mask_reg <= q_mask;
        end
        if (state_reg == ST_LOOK && !bypass)
        begin
            row_valid_reg <= rd_row[MAX_WAYS-1:0] & {MAX_WAYS{row_init_reg[set_reg]}};
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                row_rank_reg[w] <= rd_row[RANK_OFF + w*RANK_W +: RANK_W];
                row_tag_reg[w]  <= rd_row[TAG_OFF + w*TAG_W +: TAG_W];
            end
        end
        else if (fire)
        begin
            row_valid_reg <= new_valid;
            row_rank_reg  <= new_rank;
            row_tag_reg   <= new_tag;
        end
        if (fire)
        begin
            last_set_reg    <= set_reg;
            flags_reg.hit   <= hit_any;
            flags_reg.miss  <= !hit_any;
            flags_reg.evict <= do_evict;
            flags_reg.last  <= !twice_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign res_flags   = flags_reg;
    assign hit_total   = hits_reg;
    assign miss_total  = misses_reg;
    assign evict_total = evicts_reg;

    `SALRU_ASSERT_NOW(a_hit_xor_miss, out_valid_reg, flags_reg.hit ^ flags_reg.miss)
    `SALRU_ASSERT_NOW(a_evict_on_miss, out_valid_reg && flags_reg.evict, flags_reg.miss)
    `SALRU_ASSERT_NOW(a_pop_when_free, pop, (state_reg == ST_IDLE) || (state_reg == ST_EXEC))
    `SALRU_ASSERT_NEXT(a_look_then_exec, state_reg == ST_LOOK, state_reg == ST_EXEC)

endmodule

// ----- rtl/set_assoc_lru_cache_tag_sim.sv -----
// Set-associative cache tag simulator with true-LRU replacement and saturating totals.
// A load or store gives one result, a modify gives two (load then store, last set on the
// second); op code 3 is taken and gives nothing. Each access reads its set row from the
// tag RAM into registers (ST_LOOK), then in ST_EXEC decides hit, fill or eviction, updates
// the LRU ranks and writes the row back, waiting while a held result is stalled. The second
// access of a modify works on the row already held in registers. A two-entry queue lets the
// input side keep taking items while the engine works or a result waits. After reset the
// cache is empty at once: a per-set flag marks rows never written, so there is no clearing
// pass. Configuration is to be written through cfg_we/cfg_index/cfg_data only while the
// block is idle; the block does not enforce this. Registers do not flush the cache.
module set_assoc_lru_cache_tag_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [salru_pkg::OP_W-1:0]          op,
    input  logic [ADDR_BITS-1:0]                address,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                miss,
    output logic                                evict,
    output logic                                last,
    output logic [salru_pkg::CNT_W-1:0]         hit_total,
    output logic [salru_pkg::CNT_W-1:0]         miss_total,
    output logic [salru_pkg::CNT_W-1:0]         evict_total
);
    import salru_pkg::*;

    localparam int TAG_W = ADDR_BITS - 2;
    localparam int ENT_W = 1 + MAX_WAYS + TAG_W + MAX_SET_BITS;

    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [WAYS_W-1:0]       ways_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;

    logic                    acc_valid;
    logic [MAX_SET_BITS-1:0] acc_set;
    logic [TAG_W-1:0]        acc_tag;
    logic [MAX_WAYS-1:0]     acc_mask;
    logic                    acc_twice;

    logic                    q_valid;
    logic                    q_stall;
    logic [ENT_W-1:0]        q_data;
    res_flags_t              res_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            ways_reg       <= WAYS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                CFG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLOCK_BITS_W-1:0];
                default:        ;
            endcase
        end
    end

    salru_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .in_valid    (in_valid),
        .op          (op),
        .address     (address),
        .set_bits    (set_bits_reg),
        .ways_in_use (ways_reg),
        .block_bits  (block_bits_reg),
        .acc_valid   (acc_valid),
        .acc_set     (acc_set),
        .acc_tag     (acc_tag),
        .acc_mask    (acc_mask),
        .acc_twice   (acc_twice)
    );

    salru_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (acc_valid),
        .push_stall (in_stall),
        .push_data  ({acc_twice, acc_mask, acc_tag, acc_set}),
        .pop_valid  (q_valid),
        .pop_stall  (q_stall),
        .pop_data   (q_data)
    );

    salru_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_stall     (q_stall),
        .q_set       (q_data[MAX_SET_BITS-1:0]),
        .q_tag       (q_data[MAX_SET_BITS +: TAG_W]),
        .q_mask      (q_data[MAX_SET_BITS + TAG_W +: MAX_WAYS]),
        .q_twice     (q_data[ENT_W-1]),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res_flags   (res_flags),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .evict_total (evict_total)
    );

    assign hit   = res_flags.hit;
    assign miss  = res_flags.miss;
    assign evict = res_flags.evict;
    assign last  = res_flags.last;

endmodule
